// ===== rtl/core/bls_pkg.sv =====
// Shared types and request codes for the bidirectional linear search block.
package bls_pkg;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [9:0] position;
  } rsp_t;

  typedef struct packed {
    logic        load;
    logic        shift;
    logic [31:0] target;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/bls_cell.sv =====
// One storage cell: holds a word and two match bits shifted toward either end.
module bls_cell (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [31:0]         wr_data,
  input  logic                valid,
  input  bls_pkg::cell_ctrl_t ctrl,
  input  logic                l_in,
  input  logic                r_in,
  output logic                l_out,
  output logic                r_out
);

  logic [31:0] word;
  logic        lbit;
  logic        rbit;
  logic        hit;

  assign hit = valid && (word == ctrl.target);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word <= wr_data;
    end
    if (ctrl.load) begin
      lbit <= hit;
      rbit <= hit;
    end else if (ctrl.shift) begin
      lbit <= l_in;
      rbit <= r_in;
    end
  end

  assign l_out = lbit;
  assign r_out = rbit;

endmodule

// ===== rtl/core/bidirectional_linear_search.sv =====
// Top level: row of word cells plus the search sequencer.
// Append and clear give no result.
// A search runs LOAD, SCAN, FINISH; SCAN ends once the lowest and highest
// matching cells have reached the chain ends or the row is scanned; match bits
// move one cell per cycle in SCAN, and busy holds off all requests meanwhile.
// Synchronous reset empties the list; results are one-cycle strobes.
module bidirectional_linear_search #(
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bls_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output bls_pkg::rsp_t result
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {IDLE, LOAD, SCAN, FINISH} state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [IW-1:0]       step;
  logic [IW-1:0]       lo_pos;
  logic [IW-1:0]       hi_pos;
  logic                lo_found;
  logic                hi_found;
  logic [31:0]         target;
  bls_pkg::cell_ctrl_t ctrl;
  logic [DEPTH-1:0]    lchain;
  logic [DEPTH-1:0]    rchain;
  logic [DEPTH-1:0]    valid;
  logic [DEPTH-1:0]    wsel;
  logic                accept;
  logic                do_append;
  logic                lo_now;
  logic                hi_now;
  logic [CW:0]         pos_sum;
  logic [IW-1:0]       pick;

  assign accept    = start && !busy;
  assign do_append = accept && (req.req_type == bls_pkg::REQ_APPEND)
                     && (count < CW'(DEPTH));

  assign ctrl.load   = (state == LOAD);
  assign ctrl.shift  = (state == SCAN);
  assign ctrl.target = target;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign valid[gi] = (CW'(gi) < count);
      assign wsel[gi]  = do_append && (count[IW-1:0] == IW'(gi));
      bls_cell u_cell (
        .clk     (clk),
        .wr_en   (wsel[gi]),
        .wr_data (req.value),
        .valid   (valid[gi]),
        .ctrl    (ctrl),
        .l_in    ((gi == DEPTH - 1) ? 1'b0 : lchain[(gi + 1) % DEPTH]),
        .r_in    ((gi == 0) ? 1'b0 : rchain[(gi + DEPTH - 1) % DEPTH]),
        .l_out   (lchain[gi]),
        .r_out   (rchain[gi])
      );
    end
  endgenerate

  assign lo_now  = lchain[0];
  assign hi_now  = rchain[DEPTH-1];
  assign pos_sum = (CW+1)'(lo_pos) + (CW+1)'(hi_pos);
  assign pick    = (pos_sum < (CW+1)'(count)) ? lo_pos : hi_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      busy     <= 1'b0;
      done     <= 1'b0;
      lo_found <= 1'b0;
      hi_found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (do_append) begin
              count <= count + CW'(1);
            end else if (req.req_type == bls_pkg::REQ_CLEAR) begin
              count <= '0;
            end else if (req.req_type == bls_pkg::REQ_SEARCH) begin
              target   <= req.value;
              lo_found <= 1'b0;
              hi_found <= 1'b0;
              step     <= '0;
              busy     <= 1'b1;
              state    <= LOAD;
            end
          end
        end
        LOAD: begin
          state <= SCAN;
        end
        SCAN: begin
          if (!lo_found && lo_now) begin
            lo_found <= 1'b1;
            lo_pos   <= step;
          end
          if (!hi_found && hi_now) begin
            hi_found <= 1'b1;
            hi_pos   <= IW'(DEPTH - 1) - step;
          end
          step <= step + IW'(1);
          if (((lo_found || lo_now) && (hi_found || hi_now)) || step == IW'(DEPTH - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          done            <= 1'b1;
          result.found    <= lo_found;
          result.position <= lo_found ? 10'(pick) : 10'd0;
          busy            <= 1'b0;
          state           <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == bls_pkg::REQ_SEARCH) |=> busy)
    else $error("search accepted without going busy");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.position == 10'd0))
    else $error("miss reported with nonzero position");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    $past(busy) |-> $stable(count))
    else $error("list length changed during search");
`endif

endmodule
